// File: rtl/wrrtq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the weighted round-robin task queue.
// Used by wrrtq_cell and weighted_round_robin_task_queue; no dependencies.
package wrrtq_pkg;

    // Queue depth (number of cells) and task id space
    localparam int MAX_TASKS = 16;
    localparam int ID_W      = 4;
    localparam int ID_COUNT  = 1 << ID_W;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int WEIGHT_W = 8;
    localparam int BASE_W   = 10;
    localparam int SLICE_W  = BASE_W + WEIGHT_W;
    localparam int STATUS_W = 2;

    // Packed stream widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    // Reset values
    localparam logic [BASE_W-1:0]   BASE_RESET   = 10'd25;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_YIELD   = 3'd2,
        CMD_WEIGHT  = 3'd3,
        CMD_TICK    = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_DUP    = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    // One queue entry as held by a cell
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } link_t;

    // Broadcast command to every cell
    typedef struct packed {
        logic            enq;
        logic            rem;
        logic            rot;
        logic [ID_W-1:0] task_id;
    } cell_ctrl_t;

endpackage

// File: rtl/wrrtq_cell.sv
`timescale 1ns / 1ps
// One run-queue slot: holds a task id and a valid bit, shifts toward the head.
// Depends on wrrtq_pkg for the entry and control structs.
module wrrtq_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wrrtq_pkg::cell_ctrl_t  ctrl,
    input  wrrtq_pkg::link_t       right,      // neighbor one place toward the tail
    input  wrrtq_pkg::link_t       head,       // entry at the head cell
    input  logic                   prev_valid, // neighbor toward the head is occupied
    input  logic                   match_in,   // a cell nearer the head matched task_id
    output logic                   match_out,
    output wrrtq_pkg::link_t       q,
    output wrrtq_pkg::link_t       d
);

    wrrtq_pkg::link_t q_reg;
    wrrtq_pkg::link_t d_next;
    logic             hit;

    // Compare own id against the command's task id and extend the chain
    assign hit       = q_reg.valid && (q_reg.id == ctrl.task_id);
    assign match_out = match_in || hit;

    // Choose next entry: close a gap, fill the tail, or rotate
    always_comb begin
        d_next = q_reg;
        if (ctrl.rem && match_out) begin
            d_next = right;
        end else if (ctrl.enq && !q_reg.valid && prev_valid) begin
            d_next.valid = 1'b1;
            d_next.id    = ctrl.task_id;
        end else if (ctrl.rot && q_reg.valid) begin
            d_next = right.valid ? right : head;
        end
    end

    // Hold the entry; reset empties the slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else begin
            q_reg <= d_next;
        end
    end

    assign q = q_reg;
    assign d = d_next;

endmodule

// File: rtl/weighted_round_robin_task_queue.sv
`timescale 1ns / 1ps
// Weighted round-robin run queue: top level with cell chain, weights and slices.
// Depends on wrrtq_pkg and wrrtq_cell.
//
// Usage: each item on the s_ channel is one command (enqueue, remove, yield,
// set weight, timer tick). Every accepted item yields exactly one result item
// on the m_ channel carrying the head task, the empty flag, need_resched and
// a status code. The queue itself is a row of cells, one per slot, which
// shift toward the head on remove, yield and slice expiry, and fill at the
// first empty slot on enqueue; all cells act in the same cycle.
// The result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless a stalled receiver holds it; the
// combinational path runs through the head lookup, the base-times-weight
// multiply and the slice count-down. The result sits in an output register;
// s_tready stays high while that register is empty or is being drained, so a
// stalled receiver blocks new items only once a result is waiting.
// Reset (aresetn low, synchronous): queue empty, all weights one, all slices
// fresh, base_slice_ticks 25, no result pending. cfg_wr_en writes
// base_slice_ticks at any edge; write it only while the block is idle.
module weighted_round_robin_task_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: command[2:0], task_id[6:3], weight[14:7], zero[15]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wrrtq_pkg::S_DATA_W-1:0]      s_tdata,
    // m_tdata: head_task[3:0], queue_empty[4], need_resched[5], status[7:6]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wrrtq_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [wrrtq_pkg::BASE_W-1:0]        cfg_wr_data
);

    localparam int N = wrrtq_pkg::MAX_TASKS;

    wrrtq_pkg::cmd_t                    cmd;
    logic [wrrtq_pkg::ID_W-1:0]         in_id;
    logic [wrrtq_pkg::WEIGHT_W-1:0]     in_weight;
    logic                               accept;

    wrrtq_pkg::link_t                   cell_q [N];
    wrrtq_pkg::link_t                   cell_d [N];
    wrrtq_pkg::link_t                   cell_right [N];
    logic [N:0]                         match;
    logic [N-1:0]                       q_valid;
    wrrtq_pkg::cell_ctrl_t              ctrl;
    logic                               found;

    logic [wrrtq_pkg::BASE_W-1:0]       base_reg;
    logic [wrrtq_pkg::WEIGHT_W-1:0]     weight_reg [wrrtq_pkg::ID_COUNT];
    logic [wrrtq_pkg::SLICE_W-1:0]      slice_reg [wrrtq_pkg::ID_COUNT];

    logic [wrrtq_pkg::BASE_W-1:0]       base_eff;
    logic [wrrtq_pkg::WEIGHT_W-1:0]     weight_eff;
    logic [wrrtq_pkg::SLICE_W-1:0]      full_slice;
    logic [wrrtq_pkg::SLICE_W-1:0]      slice_load;
    logic [wrrtq_pkg::SLICE_W-1:0]      slice_dec;
    logic                               tick_act;
    logic                               expire;
    wrrtq_pkg::status_t                 status;

    logic                               m_valid_reg;
    logic [wrrtq_pkg::M_DATA_W-1:0]     m_data_reg;
    logic [wrrtq_pkg::M_DATA_W-1:0]     m_data_next;

    // Unpack the input item
    assign cmd       = wrrtq_pkg::cmd_t'(s_tdata[2:0]);
    assign in_id     = s_tdata[6:3];
    assign in_weight = s_tdata[14:7];

    // Accept while the output register is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Cell chain
    assign match[0] = 1'b0;
    assign found    = match[N];

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            if (gi == N - 1) begin : g_last
                assign cell_right[gi] = '0;
            end else begin : g_mid
                assign cell_right[gi] = cell_q[gi+1];
            end
            assign q_valid[gi] = cell_q[gi].valid;

            wrrtq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .right      (cell_right[gi]),
                .head       (cell_q[0]),
                .prev_valid ((gi == 0) ? 1'b1 : cell_q[(gi == 0) ? 0 : gi-1].valid),
                .match_in   (match[gi]),
                .match_out  (match[gi+1]),
                .q          (cell_q[gi]),
                .d          (cell_d[gi])
            );
        end
    endgenerate

    // Slice arithmetic for the head task
    assign base_eff   = (base_reg == '0) ? wrrtq_pkg::BASE_W'(1) : base_reg;
    assign weight_eff = (weight_reg[cell_q[0].id] == '0) ? wrrtq_pkg::WEIGHT_W'(1)
                                                          : weight_reg[cell_q[0].id];
    assign full_slice = wrrtq_pkg::SLICE_W'(base_eff) * wrrtq_pkg::SLICE_W'(weight_eff);
    assign slice_load = (slice_reg[cell_q[0].id] == '0) ? full_slice
                                                         : slice_reg[cell_q[0].id];
    assign slice_dec  = slice_load - wrrtq_pkg::SLICE_W'(1);
    assign expire     = (slice_dec == '0);
    assign tick_act   = accept && (cmd == wrrtq_pkg::CMD_TICK) && cell_q[0].valid;

    // Broadcast the command to the cells
    always_comb begin
        ctrl.task_id = in_id;
        ctrl.enq     = accept && (cmd == wrrtq_pkg::CMD_ENQUEUE) && !found;
        ctrl.rem     = accept && (cmd == wrrtq_pkg::CMD_REMOVE);
        ctrl.rot     = accept && ((cmd == wrrtq_pkg::CMD_YIELD) || (tick_act && expire));
    end

    // Status of the command
    always_comb begin
        status = wrrtq_pkg::ST_OK;
        case (cmd)
            wrrtq_pkg::CMD_ENQUEUE: begin
                if (found) begin
                    status = wrrtq_pkg::ST_DUP;
                end else if (cell_q[N-1].valid) begin
                    status = wrrtq_pkg::ST_FULL;
                end
            end
            wrrtq_pkg::CMD_REMOVE: begin
                if (!found) begin
                    status = wrrtq_pkg::ST_ABSENT;
                end
            end
            default: begin
                status = wrrtq_pkg::ST_OK;
            end
        endcase
    end

    // Build the result from the queue's next head
    always_comb begin
        m_data_next      = '0;
        m_data_next[3:0] = cell_d[0].valid ? cell_d[0].id : '0;
        m_data_next[4]   = !cell_d[0].valid;
        m_data_next[5]   = tick_act && expire;
        m_data_next[7:6] = status;
    end

    // Base slice register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= wrrtq_pkg::BASE_RESET;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    // Weight and slice tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < wrrtq_pkg::ID_COUNT; i++) begin
                weight_reg[i] <= wrrtq_pkg::WEIGHT_RESET;
                slice_reg[i]  <= '0;
            end
        end else begin
            if (accept && (cmd == wrrtq_pkg::CMD_WEIGHT)) begin
                weight_reg[in_id] <= in_weight;
            end
            if (tick_act) begin
                slice_reg[cell_q[0].id] <= expire ? full_slice : slice_dec;
            end
        end
    end

    // Output register: load on accept, drop on take
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Occupied cells stay packed toward the head
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid[N-1:1] & ~q_valid[N-2:0]) == '0)
        else $error("gap in run queue cells");

    // An empty queue reports head zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[4]) |-> (m_data_reg[3:0] == '0))
        else $error("empty queue with nonzero head");

    // Only a tick can raise need_resched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (cmd != wrrtq_pkg::CMD_TICK)) |=> !m_data_reg[5])
        else $error("need_resched without tick");

    // Yield, weight and tick always report ok
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (cmd == wrrtq_pkg::CMD_YIELD || cmd == wrrtq_pkg::CMD_WEIGHT ||
                    cmd == wrrtq_pkg::CMD_TICK))
        |=> (m_data_reg[7:6] == wrrtq_pkg::ST_OK))
        else $error("error status on non-queue command");

endmodule

// File: tb/sv/weighted_round_robin_task_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for weighted_round_robin_task_queue: directed and random
// scheduler commands, with a run-queue model that predicts each result item.
// Depends on wrrtq_pkg and the weighted_round_robin_task_queue RTL.
module weighted_round_robin_task_queue_tb;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 160;
    localparam int IDLE_PCT      = 28;
    // Command codes with no function; the block must answer them with no change
    localparam logic [wrrtq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [wrrtq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [wrrtq_pkg::CMD_W-1:0]    cmd;
        logic [wrrtq_pkg::ID_W-1:0]     task_id;
        logic [wrrtq_pkg::WEIGHT_W-1:0] weight;
        bit                             drain;   // hold this item until all results are back
    } sched_cmd_t;

    typedef struct {
        logic [wrrtq_pkg::ID_W-1:0]     head;
        logic                           empty;
        logic                           resched;
        logic [wrrtq_pkg::STATUS_W-1:0] status;
    } sched_report_t;

    logic                             aclk        = 1'b0;
    logic                             aresetn     = 1'b0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [wrrtq_pkg::S_DATA_W-1:0]   s_tdata     = '0;
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    logic [wrrtq_pkg::M_DATA_W-1:0]   m_tdata;
    logic                             cfg_wr_en   = 1'b0;
    logic [wrrtq_pkg::BASE_W-1:0]     cfg_wr_data = '0;

    // Run-queue model state
    logic [wrrtq_pkg::ID_W-1:0]     run_queue[$];
    logic [wrrtq_pkg::WEIGHT_W-1:0] weight_of[wrrtq_pkg::ID_COUNT] =
        '{default: wrrtq_pkg::WEIGHT_RESET};
    logic [wrrtq_pkg::SLICE_W-1:0]  slice_of[wrrtq_pkg::ID_COUNT]  = '{default: '0};
    logic [wrrtq_pkg::BASE_W-1:0]   base_ticks = wrrtq_pkg::BASE_RESET;

    sched_cmd_t    command_backlog[$];
    sched_cmd_t    in_flight;
    sched_report_t sched_outcomes[$];
    int            n_accepted  = 0;
    int            n_reported  = 0;
    int            n_errors    = 0;
    int            cycle_count = 0;
    bit            no_gaps     = 1'b0;

    weighted_round_robin_task_queue i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Full slice of a task: base times weight, zero of either counting as one
    function automatic logic [wrrtq_pkg::SLICE_W-1:0] fresh_slice(
            logic [wrrtq_pkg::ID_W-1:0] id);
        logic [wrrtq_pkg::SLICE_W-1:0] w;
        logic [wrrtq_pkg::SLICE_W-1:0] b;
        logic [wrrtq_pkg::SLICE_W-1:0] prod;
        w = wrrtq_pkg::SLICE_W'(weight_of[id]);
        if (w == '0) w = wrrtq_pkg::SLICE_W'(1);
        b = wrrtq_pkg::SLICE_W'(base_ticks);
        if (b == '0) b = wrrtq_pkg::SLICE_W'(1);
        prod = b * w;
        return prod;
    endfunction

    // Apply one command to the run queue and return the report it produces
    function automatic sched_report_t apply_command(sched_cmd_t c);
        sched_report_t              r;
        int                         pos;
        logic [wrrtq_pkg::ID_W-1:0] h;
        r.status  = wrrtq_pkg::ST_OK;
        r.resched = 1'b0;
        pos = -1;
        foreach (run_queue[i]) begin
            if (run_queue[i] == c.task_id) pos = i;
        end
        case (c.cmd)
            wrrtq_pkg::CMD_ENQUEUE: begin
                if (pos >= 0) r.status = wrrtq_pkg::ST_DUP;
                else if (run_queue.size() >= wrrtq_pkg::MAX_TASKS) r.status = wrrtq_pkg::ST_FULL;
                else run_queue.push_back(c.task_id);
            end
            wrrtq_pkg::CMD_REMOVE: begin
                if (pos < 0) r.status = wrrtq_pkg::ST_ABSENT;
                else run_queue.delete(pos);
            end
            wrrtq_pkg::CMD_YIELD: begin
                if (run_queue.size() != 0) run_queue.push_back(run_queue.pop_front());
            end
            wrrtq_pkg::CMD_WEIGHT: begin
                weight_of[c.task_id] = c.weight;
            end
            wrrtq_pkg::CMD_TICK: begin
                if (run_queue.size() != 0) begin
                    h = run_queue[0];
                    if (slice_of[h] == '0) slice_of[h] = fresh_slice(h);
                    slice_of[h] = slice_of[h] - 1'b1;
                    // slice used up: reload it and rotate the head to the tail
                    if (slice_of[h] == '0) begin
                        slice_of[h] = fresh_slice(h);
                        run_queue.push_back(run_queue.pop_front());
                        r.resched = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.empty = (run_queue.size() == 0);
        r.head  = r.empty ? '0 : run_queue[0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("%0t: result %0d %s: got %0h, want %0h", $realtime, n_reported,
                 what, got, want);
    endtask

    task automatic add_cmd(logic [wrrtq_pkg::CMD_W-1:0] cmd, logic [wrrtq_pkg::ID_W-1:0] id,
                           logic [wrrtq_pkg::WEIGHT_W-1:0] w);
        sched_cmd_t c;
        c.cmd     = cmd;
        c.task_id = id;
        c.weight  = w;
        c.drain   = 1'b0;
        command_backlog.push_back(c);
    endtask

    // Wait until every item is accepted and every report has come back
    task automatic wait_quiet();
        do @(negedge aclk);
        while (command_backlog.size() != 0 || s_tvalid || n_reported != n_accepted);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_base(logic [wrrtq_pkg::BASE_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        base_ticks = v;
    endtask

    // Random commands, ticks the largest share, with queue churn and spare codes mixed in
    task automatic add_random_run(int count, int enq_pct);
        sched_cmd_t c;
        int         roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < enq_pct) c.cmd = wrrtq_pkg::CMD_ENQUEUE;
            else if (roll < enq_pct + 14) c.cmd = wrrtq_pkg::CMD_REMOVE;
            else if (roll < enq_pct + 22) c.cmd = wrrtq_pkg::CMD_YIELD;
            else if (roll < enq_pct + 32) c.cmd = wrrtq_pkg::CMD_WEIGHT;
            else if (roll < 98) c.cmd = wrrtq_pkg::CMD_TICK;
            else c.cmd = wrrtq_pkg::CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
            c.task_id = wrrtq_pkg::ID_W'($urandom_range(wrrtq_pkg::ID_COUNT - 1));
            c.weight  = wrrtq_pkg::WEIGHT_W'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                                     : $urandom_range(3));
            c.drain   = ($urandom_range(59) == 0);
            command_backlog.push_back(c);
        end
    endtask

    // Stimulus: directed cases, then random phases at several slice bases
    initial begin
        logic [wrrtq_pkg::BASE_W-1:0] phase_base[6];
        phase_base = '{10'd1023, 10'd2, 10'd1, 10'd3, 10'd0, 10'd1};
        phase_base[5] = wrrtq_pkg::BASE_W'($urandom_range(1023, 1));
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty queue, duplicates, absent task, weight extremes, spare codes
        add_cmd(wrrtq_pkg::CMD_TICK, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_YIELD, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_REMOVE, 4'd15, 8'd0);
        add_cmd(wrrtq_pkg::CMD_ENQUEUE, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_ENQUEUE, 4'd15, 8'd255);
        add_cmd(wrrtq_pkg::CMD_ENQUEUE, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_WEIGHT, 4'd15, 8'd0);
        add_cmd(wrrtq_pkg::CMD_WEIGHT, 4'd0, 8'd255);
        add_cmd(wrrtq_pkg::CMD_TICK, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_YIELD, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_REMOVE, 4'd0, 8'd0);
        add_cmd(CMD_SPARE_HI, 4'd15, 8'd255);
        add_cmd(CMD_SPARE_LO, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_WEIGHT, 4'd0, 8'd1);
        wait_quiet();

        // unit base: slices expire quickly, a larger weight keeps a partly used slice
        write_base(10'd1);
        add_cmd(wrrtq_pkg::CMD_TICK, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_ENQUEUE, 4'd3, 8'd0);
        add_cmd(wrrtq_pkg::CMD_TICK, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_TICK, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_WEIGHT, 4'd3, 8'd2);
        add_cmd(wrrtq_pkg::CMD_TICK, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_TICK, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_TICK, 4'd0, 8'd0);
        add_cmd(wrrtq_pkg::CMD_REMOVE, 4'd15, 8'd0);
        add_cmd(wrrtq_pkg::CMD_REMOVE, 4'd3, 8'd0);
        add_cmd(wrrtq_pkg::CMD_TICK, 4'd0, 8'd0);
        wait_quiet();

        for (int p = 0; p < 6; p++) begin
            write_base(phase_base[p]);
            no_gaps = (p == 2);
            add_random_run(PHASE_ITEMS, (p % 2 == 0) ? 26 : 12);
            wait_quiet();
        end
        no_gaps = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Drive command items; predict each one as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sched_outcomes.push_back(apply_command(in_flight));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (command_backlog.size() != 0
                        && (no_gaps || $urandom_range(99) >= IDLE_PCT)
                        && !(command_backlog[0].drain && n_accepted != n_reported)) begin
                    in_flight = command_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, in_flight.weight, in_flight.task_id, in_flight.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side at random and check each accepted result item
    always @(posedge aclk) begin : result_check
        sched_report_t want;
        m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        if (aresetn && m_tvalid && m_tready) begin
            n_reported <= n_reported + 1;
            if (sched_outcomes.size() == 0) begin
                report_mismatch("unexpected result item", 32'(m_tdata), 32'd0);
            end else begin
                want = sched_outcomes.pop_front();
                // m_tdata: head_task[3:0], queue_empty[4], need_resched[5], status[7:6]
                if (m_tdata[3:0] !== want.head)
                    report_mismatch("head_task", 32'(m_tdata[3:0]), 32'(want.head));
                if (m_tdata[4] !== want.empty)
                    report_mismatch("queue_empty", 32'(m_tdata[4]), 32'(want.empty));
                if (m_tdata[5] !== want.resched)
                    report_mismatch("need_resched", 32'(m_tdata[5]), 32'(want.resched));
                if (m_tdata[7:6] !== want.status)
                    report_mismatch("status", 32'(m_tdata[7:6]), 32'(want.status));
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
